// File: rtl/tcce_pkg.sv
// Shared types, constants and helper functions of the text console cell engine.
package tcce_pkg;

  // Screen store geometry.
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_LINES   = 64;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_LINES);
  localparam int NCOL_W      = COL_W + 1;
  localparam int NROW_W      = ROW_W + 1;
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int CELL_DEPTH  = MAX_LINES * MAX_COLUMNS;
  localparam int CELL_W      = 16;

  // Configuration port.
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int COLS_REG_W  = 8;
  localparam int LINES_REG_W = 7;
  localparam logic [CFG_IDX_W-1:0]   CFG_COLUMNS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0]   CFG_LINES     = 1'b1;
  localparam logic [COLS_REG_W-1:0]  RESET_COLUMNS = 8'd80;
  localparam logic [LINES_REG_W-1:0] RESET_LINES   = 7'd25;

  // Operation codes.
  localparam logic [2:0] OP_PUT        = 3'd0;
  localparam logic [2:0] OP_BACKSPACE  = 3'd1;
  localparam logic [2:0] OP_PUT_AT     = 3'd2;
  localparam logic [2:0] OP_SET_COLOR  = 3'd3;
  localparam logic [2:0] OP_SET_CURSOR = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;
  localparam logic [2:0] OP_READ_CELL  = 3'd6;

  // Control characters and colours.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam int         TAB_STEP   = 4;
  localparam logic [3:0] RESET_FG   = 4'hF;
  localparam logic [3:0] RESET_BG   = 4'h0;

  // Channel payloads.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
    logic [3:0] fg_index;
    logic [3:0] bg_index;
    logic [5:0] row_sel;
    logic [6:0] col_sel;
  } cmd_item_t;

  typedef struct packed {
    logic        status;
    logic        scrolled;
    logic [5:0]  cursor_line;
    logic [6:0]  cursor_column;
    logic [7:0]  cell_char;
    logic [31:0] cell_fg_argb;
    logic [31:0] cell_bg_argb;
  } resp_item_t;

  // What an item needs after its first execute cycle.
  typedef enum logic [1:0] {
    PATH_DONE,
    PATH_SCROLL,
    PATH_FILL,
    PATH_READ
  } exec_path_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic copy_rd;
    logic copy_wr;
    logic fill_wr;
    logic init_mode;
    logic read_latch;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    exec_path_t path;
    logic       single_line;
    logic       copy_end;
    logic       fill_end;
  } dp_sts_t;

  // Pack a cell: background in the top nibble, foreground below, then character.
  function automatic logic [CELL_W-1:0] make_cell(logic [7:0] chr, logic [3:0] fg,
                                                 logic [3:0] bg);
    return {bg, fg, chr};
  endfunction

  // Sixteen-colour palette in ARGB.
  function automatic logic [31:0] palette_argb(logic [3:0] idx);
    logic [31:0] argb;
    case (idx)
      4'd0:    argb = 32'hFF000000;
      4'd1:    argb = 32'hFF0000AA;
      4'd2:    argb = 32'hFF00AA00;
      4'd3:    argb = 32'hFF00AAAA;
      4'd4:    argb = 32'hFFAA0000;
      4'd5:    argb = 32'hFFAA00AA;
      4'd6:    argb = 32'hFFAA5500;
      4'd7:    argb = 32'hFFAAAAAA;
      4'd8:    argb = 32'hFF555555;
      4'd9:    argb = 32'hFF5555FF;
      4'd10:   argb = 32'hFF55FF55;
      4'd11:   argb = 32'hFF55FFFF;
      4'd12:   argb = 32'hFFFF5555;
      4'd13:   argb = 32'hFFFF55FF;
      4'd14:   argb = 32'hFFFFFF55;
      default: argb = 32'hFFFFFFFF;
    endcase
    return argb;
  endfunction

endpackage

// File: rtl/tcce_ifs.sv
// Valid/ready channel interfaces for command items and response items.
interface tcce_cmd_if;
  logic                valid;
  logic                ready;
  tcce_pkg::cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcce_resp_if;
  logic                 valid;
  logic                 ready;
  tcce_pkg::resp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/text_console_cell_engine_top.sv
// Sequence: put, backspace, put_at, set_color and set_cursor are accepted in idle, run in
// the execute state and load the response register; read_cell adds a read-wait state, and clear
// fills lines*columns cells. A scrolling put copies each moved cell with a read state and a
// write state on the single write port of the cell memory, then blanks the bottom line.
// One item is in flight at a time; a new item is accepted only back in idle.
// After reset the whole store is cleared, during which no item is accepted.
module text_console_cell_engine_top (
  input  logic                              clk,
  input  logic                              rst,
  tcce_cmd_if.sink                          cmd,
  tcce_resp_if.source                       resp,
  input  logic                              cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tcce_pkg::*;

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  // Sequencing of each item.
  tcce_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .resp_valid (resp.valid),
    .resp_ready (resp.ready),
    .ctl        (ctl),
    .sts        (sts)
  );

  // Store, cursor and result datapath.
  tcce_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .cmd_data  (cmd.data),
    .resp_data (resp.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// File: rtl/tcce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tcce_ctrl.sv
// Controller state machine that sequences each item through the datapath.
module tcce_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  output logic                resp_valid,
  input  logic                resp_ready,
  output tcce_pkg::ctl_cmd_t  ctl,
  input  tcce_pkg::dp_sts_t   sts
);
  import tcce_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_COPY_RD,
    S_COPY_WR,
    S_FILL,
    S_READ_WAIT,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // The response register can take a new item when empty or being emptied.
  assign out_free  = !resp_valid || resp_ready;
  assign cmd_ready = (state == S_IDLE);

  // Commands and next state.
  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        ctl.fill_wr   = 1'b1;
        ctl.init_mode = 1'b1;
        if (sts.fill_end) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ctl.capture = cmd_valid;
        if (cmd_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        case (sts.path)
          PATH_SCROLL: state_next = sts.single_line ? S_FILL : S_COPY_RD;
          PATH_FILL:   state_next = S_FILL;
          PATH_READ:   state_next = S_READ_WAIT;
          default: begin
            ctl.load_out = out_free;
            state_next   = out_free ? S_IDLE : S_DONE;
          end
        endcase
      end
      S_COPY_RD: begin
        ctl.copy_rd = 1'b1;
        state_next  = S_COPY_WR;
      end
      S_COPY_WR: begin
        ctl.copy_wr = 1'b1;
        state_next  = sts.copy_end ? S_FILL : S_COPY_RD;
      end
      S_FILL: begin
        ctl.fill_wr = 1'b1;
        if (sts.fill_end) begin
          state_next = S_DONE;
        end
      end
      S_READ_WAIT: begin
        ctl.read_latch = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        ctl.load_out = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      resp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        resp_valid <= 1'b1;
      end else if (resp_ready) begin
        resp_valid <= 1'b0;
      end
    end
  end

  // An accepted item is executed in the following cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> ctl.exec)
    else $error("accepted item was not executed");

  // Cell data is only latched right after a read was issued.
  a_read_after_exec: assert property (@(posedge clk) disable iff (rst)
    ctl.read_latch |-> $past(ctl.exec))
    else $error("read data latched without a preceding read");

  // The power-up clearing pass ends in the idle state.
  a_init_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) && sts.fill_end |=> cmd_ready)
    else $error("clearing pass did not release the command channel");

endmodule

// File: rtl/tcce_datapath.sv
// Datapath: screen store, cursor, colours, configuration and response register.
module tcce_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tcce_pkg::ctl_cmd_t                  ctl,
  output tcce_pkg::dp_sts_t                   sts,
  input  tcce_pkg::cmd_item_t                 cmd_data,
  output tcce_pkg::resp_item_t                resp_data,
  input  logic                                cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tcce_pkg::*;

  logic [COLS_REG_W-1:0]  cfg_cols;
  logic [LINES_REG_W-1:0] cfg_lines;
  logic [NCOL_W-1:0]      eff_cols;
  logic [NROW_W-1:0]      eff_lines;
  logic [COL_W-1:0]       cols_last;
  logic [ROW_W-1:0]       lines_last;

  cmd_item_t              item_q;
  logic [ROW_W-1:0]       cur_line;
  logic [COL_W-1:0]       cur_col;
  logic [3:0]             cur_fg;
  logic [3:0]             cur_bg;
  logic [ROW_W-1:0]       wrow;
  logic [COL_W-1:0]       wcol;
  logic [COL_W-1:0]       walk_col_last;
  logic [ROW_W-1:0]       walk_row_last;

  logic                   res_status;
  logic                   res_scrolled;
  logic [7:0]             res_char;
  logic [31:0]            res_fg;
  logic [31:0]            res_bg;
  resp_item_t             out_q;
  resp_item_t             out_next;

  logic [CELL_W-1:0]      blank;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [CELL_W-1:0]      ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [CELL_W-1:0]      ram_rdata;

  logic                   exec_we;
  logic [ADDR_W-1:0]      exec_waddr;
  logic [CELL_W-1:0]      exec_wdata;
  logic [ROW_W-1:0]       line_next;
  logic [COL_W-1:0]       col_next;
  logic [3:0]             fg_next;
  logic [3:0]             bg_next;
  logic                   status_next;
  logic                   scrolled_next;
  exec_path_t             path;

  // Effective screen size: zero counts as one, larger values are limited to the store.
  always_comb begin
    if (cfg_cols == '0) begin
      eff_cols = NCOL_W'(1);
    end else if (int'(cfg_cols) > MAX_COLUMNS) begin
      eff_cols = NCOL_W'(MAX_COLUMNS);
    end else begin
      eff_cols = NCOL_W'(cfg_cols);
    end
    if (cfg_lines == '0) begin
      eff_lines = NROW_W'(1);
    end else if (int'(cfg_lines) > MAX_LINES) begin
      eff_lines = NROW_W'(MAX_LINES);
    end else begin
      eff_lines = NROW_W'(cfg_lines);
    end
  end

  assign cols_last  = COL_W'(eff_cols - NCOL_W'(1));
  assign lines_last = ROW_W'(eff_lines - NROW_W'(1));
  assign blank      = make_cell(CH_SPACE, cur_fg, cur_bg);

  // First execute cycle of an item: cursor update, single cell write, next path.
  always_comb begin
    logic [ROW_W-1:0]  pl;
    logic [COL_W-1:0]  pc;
    logic [NROW_W-1:0] nl;
    logic [NCOL_W-1:0] nc;
    logic              in_range;

    pl = (cur_line > lines_last) ? lines_last : cur_line;
    pc = (cur_col > cols_last) ? cols_last : cur_col;
    nl = {1'b0, pl};
    nc = {1'b0, pc};
    in_range = (NROW_W'(item_q.row_sel) < eff_lines) &&
               (NCOL_W'(item_q.col_sel) < eff_cols);

    line_next     = cur_line;
    col_next      = cur_col;
    fg_next       = cur_fg;
    bg_next       = cur_bg;
    exec_we       = 1'b0;
    exec_waddr    = {pl, pc};
    exec_wdata    = make_cell(item_q.ch, cur_fg, cur_bg);
    status_next   = 1'b0;
    scrolled_next = 1'b0;
    path          = PATH_DONE;

    case (item_q.op)
      OP_PUT: begin
        if (item_q.ch == CH_NEWLINE) begin
          nc = '0;
          nl = nl + NROW_W'(1);
        end else if (item_q.ch == CH_RETURN) begin
          nc = '0;
        end else if (item_q.ch == CH_TAB) begin
          nc = (nc + NCOL_W'(TAB_STEP)) & ~NCOL_W'(TAB_STEP - 1);
        end else begin
          exec_we = 1'b1;
          nc      = nc + NCOL_W'(1);
        end
        // Auto-wrap past the right edge.
        if (nc >= eff_cols) begin
          nc = '0;
          nl = nl + NROW_W'(1);
        end
        // Past the bottom line the screen scrolls up.
        if (nl >= eff_lines) begin
          line_next     = lines_last;
          scrolled_next = 1'b1;
          path          = PATH_SCROLL;
        end else begin
          line_next = nl[ROW_W-1:0];
        end
        col_next = nc[COL_W-1:0];
      end
      OP_BACKSPACE: begin
        line_next = pl;
        col_next  = pc;
        if (pc != '0) begin
          col_next = pc - COL_W'(1);
        end else if (pl != '0) begin
          line_next = pl - ROW_W'(1);
          col_next  = cols_last;
        end
        exec_we    = 1'b1;
        exec_waddr = {line_next, col_next};
        exec_wdata = blank;
      end
      OP_PUT_AT: begin
        if (in_range) begin
          exec_we    = 1'b1;
          exec_waddr = {ROW_W'(item_q.row_sel), COL_W'(item_q.col_sel)};
          exec_wdata = make_cell(item_q.ch, item_q.fg_index, item_q.bg_index);
        end else begin
          status_next = 1'b1;
        end
      end
      OP_SET_COLOR: begin
        fg_next = item_q.fg_index;
        bg_next = item_q.bg_index;
      end
      OP_SET_CURSOR: begin
        if (in_range) begin
          line_next = ROW_W'(item_q.row_sel);
          col_next  = COL_W'(item_q.col_sel);
        end else begin
          status_next = 1'b1;
        end
      end
      OP_CLEAR: begin
        line_next = '0;
        col_next  = '0;
        path      = PATH_FILL;
      end
      OP_READ_CELL: begin
        if (in_range) begin
          path = PATH_READ;
        end else begin
          status_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Walk limits: the whole store during the power-up pass, else the screen.
  assign walk_col_last = ctl.init_mode ? COL_W'(MAX_COLUMNS - 1) : cols_last;
  assign walk_row_last = ctl.init_mode ? ROW_W'(MAX_LINES - 1) : lines_last;

  assign sts.path        = path;
  assign sts.single_line = (lines_last == '0);
  assign sts.copy_end    = (wcol == cols_last) && ((wrow + ROW_W'(1)) == lines_last);
  assign sts.fill_end    = (wcol == walk_col_last) && (wrow == walk_row_last);

  // Memory port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {wrow, wcol};
    ram_wdata = blank;
    if (ctl.exec) begin
      ram_we    = exec_we;
      ram_waddr = exec_waddr;
      ram_wdata = exec_wdata;
    end else if (ctl.copy_wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
    end else if (ctl.fill_wr) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = ctl.copy_rd ? {wrow + ROW_W'(1), wcol}
                                 : {ROW_W'(item_q.row_sel), COL_W'(item_q.col_sel)};

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cols  <= RESET_COLUMNS;
      cfg_lines <= RESET_LINES;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLUMNS: cfg_cols  <= COLS_REG_W'(cfg_data);
        CFG_LINES:   cfg_lines <= LINES_REG_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Cursor, current colours and the cell walker.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_line <= '0;
      cur_col  <= '0;
      cur_fg   <= RESET_FG;
      cur_bg   <= RESET_BG;
      wrow     <= '0;
      wcol     <= '0;
    end else begin
      if (ctl.exec) begin
        cur_line <= line_next;
        cur_col  <= col_next;
        cur_fg   <= fg_next;
        cur_bg   <= bg_next;
        wrow     <= '0;
        wcol     <= '0;
      end else if (ctl.copy_wr || ctl.fill_wr) begin
        if (wcol == walk_col_last) begin
          wcol <= '0;
          wrow <= wrow + ROW_W'(1);
        end else begin
          wcol <= wcol + COL_W'(1);
        end
      end
    end
  end

  // Captured item and per-item results.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_q <= cmd_data;
    end
    if (ctl.exec) begin
      res_status   <= status_next;
      res_scrolled <= scrolled_next;
      res_char     <= '0;
      res_fg       <= '0;
      res_bg       <= '0;
    end else if (ctl.read_latch) begin
      res_char <= ram_rdata[7:0];
      res_fg   <= palette_argb(ram_rdata[11:8]);
      res_bg   <= palette_argb(ram_rdata[15:12]);
    end
    if (ctl.load_out) begin
      out_q <= out_next;
    end
  end

  // Response item, taken straight from the execute cycle when nothing follows.
  always_comb begin
    if (ctl.exec) begin
      out_next.status        = status_next;
      out_next.scrolled      = scrolled_next;
      out_next.cursor_line   = 6'(line_next);
      out_next.cursor_column = 7'(col_next);
      out_next.cell_char     = '0;
      out_next.cell_fg_argb  = '0;
      out_next.cell_bg_argb  = '0;
    end else begin
      out_next.status        = res_status;
      out_next.scrolled      = res_scrolled;
      out_next.cursor_line   = 6'(cur_line);
      out_next.cursor_column = 7'(cur_col);
      out_next.cell_char     = res_char;
      out_next.cell_fg_argb  = res_fg;
      out_next.cell_bg_argb  = res_bg;
    end
  end

  assign resp_data = out_q;

  // A put always leaves the cursor on the screen it was executed against.
  a_put_on_screen: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(ctl.exec) && ($past(item_q.op) == OP_PUT) |->
      (cur_line <= $past(lines_last)) && (cur_col <= $past(cols_last)))
    else $error("cursor left the screen after a put");

  // A scrolling item leaves the cursor on the bottom line.
  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && $past(ctl.exec) && res_scrolled |-> (cur_line == $past(lines_last)))
    else $error("scroll did not park the cursor on the bottom line");

endmodule

// File: bench/text_console_cell_engine_top_tb.sv
// Self-checking testbench for the text console cell engine: directed and random console traffic.
`timescale 1ns / 100ps

module text_console_cell_engine_top_tb;
  import tcce_pkg::*;

  // Unassigned operation code, which the block must ignore.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam int IDLE_PCT       = 19;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 125;

  // Sixteen palette entries, entry 0 in the lowest 32 bits.
  localparam logic [16*32-1:0] ARGB_TABLE = {
    32'hFFFFFFFF, 32'hFFFFFF55, 32'hFFFF55FF, 32'hFFFF5555,
    32'hFF55FFFF, 32'hFF55FF55, 32'hFF5555FF, 32'hFF555555,
    32'hFFAAAAAA, 32'hFFAA5500, 32'hFFAA00AA, 32'hFFAA0000,
    32'hFF00AAAA, 32'hFF00AA00, 32'hFF0000AA, 32'hFF000000
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tcce_cmd_if  cmd_ch ();
  tcce_resp_if resp_ch ();

  text_console_cell_engine_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .resp      (resp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted console state.
  logic [CELL_W-1:0] screen [0:CELL_DEPTH-1];
  int                cur_line;
  int                cur_col;
  logic [3:0]        pen_fg;
  logic [3:0]        pen_bg;
  logic [7:0]        cols_set;
  logic [6:0]        lines_set;

  resp_item_t console_replies [$];
  resp_item_t want_reply;
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  bit         steady       = 1'b0;

  always #2 clk = ~clk;

  // Visible screen size after clamping the registers.
  function automatic int screen_cols();
    if (cols_set < 1) return 1;
    if (cols_set > MAX_COLUMNS) return MAX_COLUMNS;
    return cols_set;
  endfunction

  function automatic int screen_lines();
    if (lines_set < 1) return 1;
    if (lines_set > MAX_LINES) return MAX_LINES;
    return lines_set;
  endfunction

  // Apply one command to the predicted console and return the reply it should produce.
  function automatic resp_item_t console_apply(input cmd_item_t c);
    resp_item_t        r;
    int                ncol;
    int                nrow;
    int                ln;
    int                cl;
    logic [CELL_W-1:0] blank;
    logic [CELL_W-1:0] got;
    bit                hit;
    ncol  = screen_cols();
    nrow  = screen_lines();
    r     = '0;
    blank = {pen_bg, pen_fg, CH_SPACE};
    hit   = (c.row_sel < nrow) && (c.col_sel < ncol);
    // A screen shrunk under the cursor pulls it back into view first.
    if (c.op == OP_PUT || c.op == OP_BACKSPACE) begin
      if (cur_col >= ncol) cur_col = ncol - 1;
      if (cur_line >= nrow) cur_line = nrow - 1;
    end
    case (c.op)
      OP_PUT: begin
        if (c.ch == CH_NEWLINE) begin
          cur_col = 0;
          cur_line++;
        end else if (c.ch == CH_RETURN) begin
          cur_col = 0;
        end else if (c.ch == CH_TAB) begin
          cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
        end else begin
          screen[cur_line * MAX_COLUMNS + cur_col] = {pen_bg, pen_fg, c.ch};
          cur_col++;
        end
        if (cur_col >= ncol) begin
          cur_col = 0;
          cur_line++;
        end
        // Past the last line: move the visible lines up and blank the bottom one.
        if (cur_line >= nrow) begin
          for (ln = 0; ln + 1 < nrow; ln++)
            for (cl = 0; cl < ncol; cl++)
              screen[ln * MAX_COLUMNS + cl] = screen[(ln + 1) * MAX_COLUMNS + cl];
          for (cl = 0; cl < ncol; cl++)
            screen[(nrow - 1) * MAX_COLUMNS + cl] = blank;
          cur_line   = nrow - 1;
          r.scrolled = 1'b1;
        end
      end
      OP_BACKSPACE: begin
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_line > 0) begin
          cur_line--;
          cur_col = ncol - 1;
        end
        screen[cur_line * MAX_COLUMNS + cur_col] = blank;
      end
      OP_PUT_AT: begin
        if (hit) screen[c.row_sel * MAX_COLUMNS + c.col_sel] = {c.bg_index, c.fg_index, c.ch};
        else r.status = 1'b1;
      end
      OP_SET_COLOR: begin
        pen_fg = c.fg_index;
        pen_bg = c.bg_index;
      end
      OP_SET_CURSOR: begin
        if (hit) begin
          cur_line = c.row_sel;
          cur_col  = c.col_sel;
        end else begin
          r.status = 1'b1;
        end
      end
      OP_CLEAR: begin
        for (ln = 0; ln < nrow; ln++)
          for (cl = 0; cl < ncol; cl++)
            screen[ln * MAX_COLUMNS + cl] = blank;
        cur_line = 0;
        cur_col  = 0;
      end
      OP_READ_CELL: begin
        if (hit) begin
          got            = screen[c.row_sel * MAX_COLUMNS + c.col_sel];
          r.cell_char    = got[7:0];
          r.cell_fg_argb = ARGB_TABLE[int'(got[11:8]) * 32 +: 32];
          r.cell_bg_argb = ARGB_TABLE[int'(got[15:12]) * 32 +: 32];
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.cursor_line   = 6'(cur_line);
    r.cursor_column = 7'(cur_col);
    return r;
  endfunction

  function automatic cmd_item_t console_cmd(input logic [2:0] op, input logic [7:0] ch,
                                            input logic [3:0] fg, input logic [3:0] bg,
                                            input logic [5:0] row, input logic [6:0] col);
    cmd_item_t c;
    c.op       = op;
    c.ch       = ch;
    c.fg_index = fg;
    c.bg_index = bg;
    c.row_sel  = row;
    c.col_sel  = col;
    return c;
  endfunction

  // Mostly console-like traffic with random content, plus some noise.
  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int        pick;
    c    = cmd_item_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      c.op = OP_PUT;
    end else if (pick < 50) begin
      c.op = OP_PUT;
      case ($urandom_range(0, 2))
        0:       c.ch = CH_NEWLINE;
        1:       c.ch = CH_RETURN;
        default: c.ch = CH_TAB;
      endcase
    end else if (pick < 58) begin
      c.op = OP_BACKSPACE;
    end else if (pick < 68) begin
      c.op = OP_PUT_AT;
    end else if (pick < 73) begin
      c.op = OP_SET_COLOR;
    end else if (pick < 80) begin
      c.op = OP_SET_CURSOR;
    end else if (pick < 82) begin
      c.op = OP_CLEAR;
    end else if (pick < 96) begin
      c.op = OP_READ_CELL;
    end
    // Positioned ops usually land on the visible screen.
    if ((c.op == OP_PUT_AT || c.op == OP_SET_CURSOR || c.op == OP_READ_CELL) &&
        $urandom_range(0, 99) < 85) begin
      c.row_sel = 6'($urandom_range(0, screen_lines() - 1));
      c.col_sel = 7'($urandom_range(0, screen_cols() - 1));
    end
    return c;
  endfunction

  // Offer one item, idling at random first, and record its reply once it is taken.
  task automatic send_cmd(input cmd_item_t item);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= item;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    console_replies.push_back(console_apply(item));
    @(negedge clk);
  endtask

  // Stop sending and wait until every reply has come back.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (console_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both geometry registers; only called while the block is idle.
  task automatic set_geometry(input logic [7:0] cols, input logic [7:0] lines);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLUMNS;
    cfg_data  <= cols;
    @(negedge clk);
    cfg_index <= CFG_LINES;
    cfg_data  <= lines;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cols_set  = cols;
    lines_set = lines[6:0];
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %h, got %h", name, want, got);
    end
  endtask

  // The reset store holds spaces in white on black; out-of-range reads are refused.
  task automatic test_reset_state();
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_READ_CELL, 8'hFF, 4'hF, 4'hF, 6'd24, 7'd79));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 6'd25, 7'd0));
  endtask

  // Printable byte, tab, carriage return, newline and the zero byte.
  task automatic test_control_chars();
    send_cmd(console_cmd(OP_PUT, 8'h41, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_PUT, CH_TAB, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_PUT, CH_RETURN, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_PUT, CH_NEWLINE, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_PUT, 8'h00, 4'hF, 4'hF, 6'd63, 7'd127));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 6'd1, 7'd0));
  endtask

  // Direct cell writes in the corner and just outside the screen.
  task automatic test_put_at();
    send_cmd(console_cmd(OP_PUT_AT, 8'hFF, 4'h0, 4'hF, 6'd24, 7'd79));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 6'd24, 7'd79));
    send_cmd(console_cmd(OP_PUT_AT, 8'h55, 4'h3, 4'h3, 6'd0, 7'd80));
  endtask

  // New colours, backspace at the origin and across a line, cursor limits, unused op.
  task automatic test_colours_and_backspace();
    send_cmd(console_cmd(OP_SET_COLOR, 8'h00, 4'h1, 4'h6, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_BACKSPACE, 8'h00, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 6'd63, 7'd127));
    send_cmd(console_cmd(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 6'd1, 7'd0));
    send_cmd(console_cmd(OP_BACKSPACE, 8'h00, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_UNUSED, 8'hAA, 4'h5, 4'hA, 6'd21, 7'd42));
  endtask

  // A tab past the last stop and a wrap on the bottom line both scroll; then clear.
  task automatic test_scroll_edges();
    send_cmd(console_cmd(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 6'd24, 7'd78));
    send_cmd(console_cmd(OP_PUT, CH_TAB, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 6'd24, 7'd79));
    send_cmd(console_cmd(OP_PUT, 8'h7E, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 6'd22, 7'd79));
    send_cmd(console_cmd(OP_CLEAR, 8'h00, 4'h0, 4'h0, 6'd0, 7'd0));
  endtask

  // Registers above their limits clamp to the full store; scroll and clear all of it.
  task automatic test_large_screen();
    settle();
    set_geometry(8'hFF, 8'hFF);
    send_cmd(console_cmd(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 6'd63, 7'd127));
    send_cmd(console_cmd(OP_PUT, 8'h58, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 6'd62, 7'd127));
    send_cmd(console_cmd(OP_CLEAR, 8'h00, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_SET_CURSOR, 8'h00, 4'h0, 4'h0, 6'd40, 7'd100));
  endtask

  // Zero registers count as one; the cursor left off screen is pulled back in.
  task automatic test_tiny_screen();
    settle();
    set_geometry(8'h00, 8'h00);
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_PUT, 8'h5A, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_BACKSPACE, 8'h00, 4'h0, 4'h0, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_PUT_AT, 8'hC3, 4'hF, 4'hF, 6'd0, 7'd0));
    send_cmd(console_cmd(OP_READ_CELL, 8'h00, 4'h0, 4'h0, 6'd0, 7'd0));
  endtask

  // Random phases, each on its own screen geometry; mostly small screens to keep scrolls short.
  task automatic test_random_traffic();
    int phase;
    int n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0:       set_geometry(8'($urandom_range(0, 16)), 8'($urandom_range(0, 8)));
        3:       set_geometry(8'($urandom_range(129, 255)), 8'($urandom_range(1, 3)));
        5:       set_geometry(8'($urandom_range(1, 4)), 8'($urandom_range(65, 127)));
        6:       set_geometry(8'($urandom_range(40, 80)), 8'($urandom_range(10, 25)));
        default: set_geometry(8'($urandom_range(1, 24)), 8'($urandom_range(1, 12)));
      endcase
      steady = (phase == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Once, hold the sender back until every reply is in.
        if (phase == 4 && n == PHASE_ITEMS / 2) settle();
        send_cmd(random_cmd());
      end
    end
    steady = 1'b0;
  endtask

  // Receiver stalls at random except during the steady stretch.
  always @(negedge clk) begin
    resp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Compare each reply with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && resp_ch.valid && resp_ch.ready) begin
      if (console_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("reply with none predicted: %h", resp_ch.data);
      end else begin
        want_reply = console_replies.pop_front();
        check_field("status", want_reply.status, resp_ch.data.status);
        check_field("scrolled", want_reply.scrolled, resp_ch.data.scrolled);
        check_field("cursor_line", want_reply.cursor_line, resp_ch.data.cursor_line);
        check_field("cursor_column", want_reply.cursor_column, resp_ch.data.cursor_column);
        check_field("cell_char", want_reply.cell_char, resp_ch.data.cell_char);
        check_field("cell_fg_argb", want_reply.cell_fg_argb, resp_ch.data.cell_fg_argb);
        check_field("cell_bg_argb", want_reply.cell_bg_argb, resp_ch.data.cell_bg_argb);
      end
    end
  end

  // Watchdog on cycles without any accepted item on either channel.
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (resp_ch.valid && resp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("text_console_cell_engine_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int i;
    rst           = 1'b1;
    cmd_ch.valid  = 1'b0;
    cmd_ch.data   = '0;
    resp_ch.ready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_COLUMNS;
    cfg_data      = '0;
    // Predicted state after reset.
    for (i = 0; i < CELL_DEPTH; i++) screen[i] = {RESET_BG, RESET_FG, CH_SPACE};
    cur_line  = 0;
    cur_col   = 0;
    pen_fg    = RESET_FG;
    pen_bg    = RESET_BG;
    cols_set  = RESET_COLUMNS;
    lines_set = RESET_LINES;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_control_chars();
    test_put_at();
    test_colours_and_backspace();
    test_scroll_edges();
    test_large_screen();
    test_tiny_screen();
    test_random_traffic();

    settle();
    if (console_replies.size() != 0) mismatches++;
    if (mismatches == 0)
      $display("text_console_cell_engine_top_tb: done, clean");
    else
      $display("text_console_cell_engine_top_tb: done, errors");
    $finish;
  end

endmodule
